// ===== hw/rtl/iptc_rd_pkg.sv =====
// types and constants shared by the iptc record deframer
package iptc_rd_pkg;

    localparam logic [7:0]  MARKER_BYTE = 8'h1C;
    localparam logic [7:0]  RECORD_SKIP = 8'h01;
    localparam logic [7:0]  RECORD_DATA = 8'h02;
    localparam logic [16:0] HEADER_TAIL = 17'd5;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       block_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0] dataset_type;
        logic [7:0] out_byte;
        logic       field_first;
        logic       field_last;
        logic       empty_field;
        logic       truncated;
    } t_out_item;

endpackage

// ===== hw/rtl/iptc_record_deframer_unit.sv =====
// IPTC-IIM record deframer: walks dataset headers of a byte stream and emits
// record 2 data bytes with field marks.
// Takes one byte per clock while no waiting result holds the input. Each byte
// lands in an input register, goes through one pass of header/field logic
// against the parser state, and any result is held in an output register,
// from which it is presented. A waiting result stalls the input only once the
// input register is full as well: a new byte is still taken while a finished
// result waits for its transfer, as long as the input register is free.
// block_length is to be written through its own port only while the block is
// idle; the block itself does not enforce this. It bounds where headers may
// start and where fields are cut off (truncated).
// A byte with block_start set restarts the parser at position zero.
module iptc_record_deframer_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  iptc_rd_pkg::t_in_item  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output iptc_rd_pkg::t_out_item o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [15:0]            i_cfg_data
);

    localparam logic [2:0] PH_WAIT    = 3'd0;
    localparam logic [2:0] PH_RECORD  = 3'd1;
    localparam logic [2:0] PH_TYPE    = 3'd2;
    localparam logic [2:0] PH_LEN_HI  = 3'd3;
    localparam logic [2:0] PH_LEN_LO  = 3'd4;
    localparam logic [2:0] PH_DATA    = 3'd5;
    localparam logic [2:0] PH_SKIP    = 3'd6;
    localparam logic [2:0] PH_STOPPED = 3'd7;

    logic [15:0]           r_block_length;
    logic                  r_in_valid;
    iptc_rd_pkg::t_in_item r_in_data;
    logic                  r_out_valid;
    iptc_rd_pkg::t_out_item r_out_data;

    logic [2:0]  r_phase,  n_phase;
    logic [15:0] r_pos,    n_pos;
    logic [15:0] r_left,   n_left;
    logic [7:0]  r_type,   n_type;
    logic [7:0]  r_record, n_record;
    logic [7:0]  r_len_hi, n_len_hi;
    logic        r_first,  n_first;

    logic                   advance;
    logic                   n_emit;
    iptc_rd_pkg::t_out_item n_out;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        logic [7:0]  b;
        logic [2:0]  ph;
        logic [15:0] pos;
        logic [15:0] left;
        logic [7:0]  cur_type;
        logic [7:0]  cur_record;
        logic [7:0]  len_hi;
        logic        first;
        logic [15:0] new_left;
        logic        at_end;
        logic        done;

        b          = r_in_data.in_byte;
        // block start restarts the parser on this byte
        ph         = r_in_data.block_start ? PH_WAIT : r_phase;
        pos        = r_in_data.block_start ? 16'd0   : r_pos;
        left       = r_in_data.block_start ? 16'd0   : r_left;
        cur_type   = r_in_data.block_start ? 8'd0    : r_type;
        cur_record = r_in_data.block_start ? 8'd0    : r_record;
        len_hi     = r_in_data.block_start ? 8'd0    : r_len_hi;
        first      = r_in_data.block_start ? 1'b0    : r_first;
        new_left   = {len_hi, b};
        at_end     = ({1'b0, pos} + 17'd1) >= {1'b0, r_block_length};
        done       = left <= 16'd1;

        n_phase  = ph;
        n_left   = left;
        n_type   = cur_type;
        n_record = cur_record;
        n_len_hi = len_hi;
        n_first  = first;
        n_pos    = (pos == 16'hFFFF) ? pos : pos + 16'd1;
        n_emit   = 1'b0;
        n_out    = '{dataset_type: cur_type, out_byte: b, field_first: 1'b0,
                     field_last: 1'b0, empty_field: 1'b0, truncated: 1'b0};

        if (pos >= r_block_length) begin
            n_phase = PH_STOPPED;
        end else begin
            unique case (ph)
                PH_WAIT: begin
                    if (({1'b0, pos} + iptc_rd_pkg::HEADER_TAIL) >= {1'b0, r_block_length}
                        || b != iptc_rd_pkg::MARKER_BYTE) begin
                        n_phase = PH_STOPPED;
                    end else begin
                        n_phase = PH_RECORD;
                    end
                end
                PH_RECORD: begin
                    n_record = b;
                    n_phase  = PH_TYPE;
                end
                PH_TYPE: begin
                    n_type  = b;
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len_hi = b;
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_left = new_left;
                    if (cur_record == iptc_rd_pkg::RECORD_SKIP) begin
                        n_phase = (new_left == 16'd0) ? PH_WAIT : PH_SKIP;
                    end else if (cur_record == iptc_rd_pkg::RECORD_DATA) begin
                        if (new_left == 16'd0) begin
                            n_emit            = 1'b1;
                            n_out.out_byte    = 8'd0;
                            n_out.field_first = 1'b1;
                            n_out.field_last  = 1'b1;
                            n_out.empty_field = 1'b1;
                            n_phase           = PH_WAIT;
                        end else begin
                            n_first = 1'b1;
                            n_phase = PH_DATA;
                        end
                    end else begin
                        n_phase = PH_STOPPED;
                    end
                end
                PH_DATA: begin
                    n_emit            = 1'b1;
                    n_out.field_first = first;
                    n_out.field_last  = done || at_end;
                    n_out.truncated   = at_end && !done;
                    n_first           = 1'b0;
                    if (left != 16'd0) begin
                        n_left = left - 16'd1;
                    end
                    if (done) begin
                        n_phase = PH_WAIT;
                    end else if (at_end) begin
                        n_phase = PH_STOPPED;
                    end
                end
                PH_SKIP: begin
                    if (left > 16'd1) begin
                        n_left = left - 16'd1;
                    end else begin
                        n_left  = 16'd0;
                        n_phase = PH_WAIT;
                    end
                end
                default: begin
                    n_phase = PH_STOPPED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= 16'd0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_phase        <= PH_WAIT;
            r_pos          <= 16'd0;
            r_left         <= 16'd0;
            r_type         <= 8'd0;
            r_record       <= 8'd0;
            r_len_hi       <= 8'd0;
            r_first        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_block_length <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= n_emit;
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_left      <= n_left;
                r_type      <= n_type;
                r_record    <= n_record;
                r_len_hi    <= n_len_hi;
                r_first     <= n_first;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (advance && n_emit) begin
            r_out_data <= n_out;
        end
    end

    a_empty_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.empty_field) |->
        (o_out_data.field_first && o_out_data.field_last && o_out_data.out_byte == 8'd0))
        else $error("empty field without first/last marks or with data");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.truncated) |-> o_out_data.field_last)
        else $error("truncated transfer without last mark");

    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_left != 16'd0))
        else $error("field open with no bytes left");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_phase) && $stable(r_pos)))
        else $error("stalled byte lost or parser moved without a byte");

endmodule
